// ===== hw/rtl/lmfb_pkg.sv =====
// Shared types, constants and frame packing functions for the LED matrix frame buffer driver.
package lmfb_pkg;

  localparam int CHAIN_DEVICES = 2;
  localparam int MATRIX_ROWS   = 8;
  localparam int BLOCK_SIZE    = 8;
  localparam int WORD_BITS     = 16;
  localparam int FRAME_W       = 32;
  localparam int ROW_W         = BLOCK_SIZE * CHAIN_DEVICES;
  localparam int TOTAL_COLS    = ROW_W;
  localparam int COL_W         = $clog2(TOTAL_COLS);
  localparam int ROW_IDX_W     = $clog2(MATRIX_ROWS);
  localparam int FILL_MAX      = BLOCK_SIZE * BLOCK_SIZE;
  localparam int CNT_W         = $clog2(FILL_MAX + 1);

  localparam logic [7:0] NOOP_BYTE = 8'h00;

  typedef enum logic [2:0] {
    KIND_PIXEL   = 3'd0,
    KIND_CLEAR   = 3'd1,
    KIND_UPDATE  = 3'd2,
    KIND_CMD_ONE = 3'd3,
    KIND_CMD_ALL = 3'd4,
    KIND_FILL    = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_CLR,
    ST_UPD_RD,
    ST_UPD_EMIT,
    ST_CMD,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] pixel_col;
    logic [7:0] pixel_row;
    logic       pixel_on;
    logic       target_device;
    logic [7:0] register_addr;
    logic [7:0] register_value;
    logic [7:0] fill_count;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] chain_frame;
    logic               last_frame;
  } out_item_t;

  // Slot 0 is shifted in first and ends up in the top bits; wider chains keep the last slots.
  function automatic logic [FRAME_W-1:0] pack_frame(input logic [7:0]       addr,
                                                    input logic [ROW_W-1:0] bits);
    logic [FRAME_W-1:0] f;
    f = '0;
    for (int d = 0; d < CHAIN_DEVICES; d++) begin
      f = {f[FRAME_W-WORD_BITS-1:0], addr, bits[8*d +: 8]};
    end
    return f;
  endfunction

  function automatic logic [FRAME_W-1:0] cmd_frame(input logic       all_dev,
                                                   input logic       tgt,
                                                   input logic [7:0] addr,
                                                   input logic [7:0] val);
    logic [FRAME_W-1:0]   f;
    logic [WORD_BITS-1:0] w;
    f = '0;
    for (int d = 0; d < CHAIN_DEVICES; d++) begin
      w = (all_dev || (d == int'(tgt))) ? {addr, val} : {NOOP_BYTE, NOOP_BYTE};
      f = {f[FRAME_W-WORD_BITS-1:0], w};
    end
    return f;
  endfunction

endpackage

// ===== hw/rtl/lmfb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lmfb_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/led_matrix_frame_buffer_driver.sv =====
// Top level: pixel frame buffer and chain frame sequencer for chained 8x8 LED matrix drivers.
//
//   Port group  Dir  Handshake           Payload
//   in_*        in   in_valid/in_stall   in_item_t  (kind, pixel, command, fill fields)
//   out_*       out  out_valid/out_stall out_item_t (chain_frame, last_frame)
//
// One item is worked on at a time. A pixel write reads, modifies and writes back its row
// through the row RAM. For an update, each row passes through a RAM read state and then a
// state that loads the output register.
// A fill level sends 8 clear frames, then 8 rows that are written and sent together.
// Reset clears the row valid bits at once, so the buffer reads dark without a clearing pass.
// A stall on the output holds the sequencer in place; the input stalls while busy.
module led_matrix_frame_buffer_driver
  import lmfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(MATRIX_ROWS - 1);

  state_t                 state_r,   state_nxt;
  logic [ROW_IDX_W-1:0]   row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]       col_r,     col_nxt;
  logic                   on_r,      on_nxt;
  logic                   fill_r,    fill_nxt;
  logic [CNT_W-1:0]       cnt_r,     cnt_nxt;
  logic [FRAME_W-1:0]     cmd_r,     cmd_nxt;
  logic [MATRIX_ROWS-1:0] valid_r,   valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r,  out_item_nxt;

  logic             in_take;
  logic             load_ok;
  logic             emit;
  logic             ram_we;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] row_bits;
  logic [ROW_W-1:0] pix_bit;
  logic [7:0]       fill_mask;
  logic [CNT_W-1:0] fill_base;
  logic [7:0]       row_addr;
  logic             last_row;

  // Row store; rows never written since the last clear read through the valid mask as dark.
  lmfb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MATRIX_ROWS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (row_cnt_r),
    .wr_data (ram_wdata),
    .rd_addr (row_cnt_r),
    .rd_data (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign load_ok   = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign row_bits = ram_rdata & {ROW_W{valid_r[row_cnt_r]}};
  assign pix_bit  = ROW_W'(1) << col_r;
  assign row_addr = 8'(row_cnt_r) + 8'd1;
  assign last_row = (row_cnt_r == LAST_ROW);

  // Fill pattern for the current row: full, partial (low bits of the count) or dark.
  assign fill_base = CNT_W'({row_cnt_r, 3'b000});
  always_comb begin
    if (cnt_r >= fill_base + CNT_W'(BLOCK_SIZE)) begin
      fill_mask = 8'hFF;
    end else if (cnt_r > fill_base) begin
      fill_mask = 8'((9'd1 << cnt_r[2:0]) - 9'd1);
    end else begin
      fill_mask = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_cnt_r  <= row_cnt_nxt;
    col_r      <= col_nxt;
    on_r       <= on_nxt;
    fill_r     <= fill_nxt;
    cnt_r      <= cnt_nxt;
    cmd_r      <= cmd_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    row_cnt_nxt  = row_cnt_r;
    col_nxt      = col_r;
    on_nxt       = on_r;
    fill_nxt     = fill_r;
    cnt_nxt      = cnt_r;
    cmd_nxt      = cmd_r;
    valid_nxt    = valid_r;
    ram_we       = 1'b0;
    ram_wdata    = row_bits;
    emit         = 1'b0;
    out_item_nxt = out_item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_data.kind) inside
            KIND_PIXEL: begin
              // Drop pixels outside the chain width or the row count.
              if (in_data.pixel_col < 8'(TOTAL_COLS) && in_data.pixel_row < 8'(MATRIX_ROWS)) begin
                row_cnt_nxt = in_data.pixel_row[ROW_IDX_W-1:0];
                col_nxt     = in_data.pixel_col[COL_W-1:0];
                on_nxt      = in_data.pixel_on;
                state_nxt   = ST_PIX_RD;
              end
            end
            KIND_CLEAR: begin
              valid_nxt   = '0;
              row_cnt_nxt = '0;
              fill_nxt    = 1'b0;
              state_nxt   = ST_CLR;
            end
            KIND_UPDATE: begin
              row_cnt_nxt = '0;
              state_nxt   = ST_UPD_RD;
            end
            KIND_CMD_ONE, KIND_CMD_ALL: begin
              cmd_nxt   = cmd_frame(in_data.kind == KIND_CMD_ALL, in_data.target_device,
                                    in_data.register_addr, in_data.register_value);
              state_nxt = ST_CMD;
            end
            KIND_FILL: begin
              valid_nxt   = '0;
              row_cnt_nxt = '0;
              fill_nxt    = 1'b1;
              cnt_nxt     = (in_data.fill_count > 8'(FILL_MAX)) ? CNT_W'(FILL_MAX)
                                                                 : in_data.fill_count[CNT_W-1:0];
              state_nxt   = ST_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PIX_RD: begin
        state_nxt = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        ram_we              = 1'b1;
        ram_wdata           = on_r ? (row_bits | pix_bit) : (row_bits & ~pix_bit);
        valid_nxt[row_cnt_r] = 1'b1;
        state_nxt           = ST_IDLE;
      end
      ST_CLR: begin
        if (load_ok) begin
          emit         = 1'b1;
          out_item_nxt = '{chain_frame: pack_frame(row_addr, '0),
                           last_frame:  !fill_r && last_row};
          if (last_row) begin
            row_cnt_nxt = '0;
            state_nxt   = fill_r ? ST_FILL : ST_IDLE;
          end else begin
            row_cnt_nxt = row_cnt_r + 1'b1;
          end
        end
      end
      ST_UPD_RD: begin
        state_nxt = ST_UPD_EMIT;
      end
      ST_UPD_EMIT: begin
        // Read data holds while stalled: the read address only moves on a transfer.
        if (load_ok) begin
          emit         = 1'b1;
          out_item_nxt = '{chain_frame: pack_frame(row_addr, row_bits), last_frame: last_row};
          if (last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            row_cnt_nxt = row_cnt_r + 1'b1;
            state_nxt   = ST_UPD_RD;
          end
        end
      end
      ST_CMD: begin
        if (load_ok) begin
          emit         = 1'b1;
          out_item_nxt = '{chain_frame: cmd_r, last_frame: 1'b1};
          state_nxt    = ST_IDLE;
        end
      end
      ST_FILL: begin
        // Write the fill row and send it in the same cycle; the store was just cleared.
        if (load_ok) begin
          emit                 = 1'b1;
          ram_we               = 1'b1;
          ram_wdata            = ROW_W'(fill_mask);
          valid_nxt[row_cnt_r] = 1'b1;
          out_item_nxt         = '{chain_frame: pack_frame(row_addr, ROW_W'(fill_mask)),
                                   last_frame:  last_row};
          if (last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            row_cnt_nxt = row_cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

// ===== sim/tb_led_matrix_frame_buffer_driver.sv =====
// Self-checking testbench for the LED matrix frame buffer driver: pixel, command and fill traffic.
module tb_led_matrix_frame_buffer_driver
  import lmfb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Enables random gaps on the input and random stalls on the output.
  bit idle_en = 1'b1;
  int mismatch_count = 0;
  int stall_left = 0;

  // Shadow copy of the pixel store and the chain frames still owed by the block.
  logic [ROW_W-1:0] frame_pixels [MATRIX_ROWS];
  out_item_t        pending_frames [$];

  led_matrix_frame_buffer_driver u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame prediction
  // ---------------------------------------------------------------------------

  // Build one chain frame: slot 0 is shifted in first so it lands in the top bits;
  // a chain wider than the frame keeps only its last slots.
  function automatic logic [FRAME_W-1:0] row_frame(input logic [7:0]       addr,
                                                   input logic [ROW_W-1:0] bits);
    logic [FRAME_W-1:0] f;
    f = '0;
    for (int d = 0; d < CHAIN_DEVICES; d++) begin
      f = (f << WORD_BITS) | {addr, bits[8*d +: 8]};
    end
    return f;
  endfunction

  function automatic void push_frame(input logic [FRAME_W-1:0] f);
    out_item_t o;
    o.chain_frame = f;
    o.last_frame  = 1'b0;
    pending_frames.push_back(o);
  endfunction

  // Clear always sends 8 zero row frames, addresses 1..8.
  function automatic void push_clear();
    for (int r = 0; r < MATRIX_ROWS; r++) frame_pixels[r] = '0;
    for (int r = 0; r < BLOCK_SIZE; r++) push_frame(row_frame(8'(r + 1), '0));
  endfunction

  function automatic void push_update();
    for (int r = 0; r < MATRIX_ROWS; r++) push_frame(row_frame(8'(r + 1), frame_pixels[r]));
  endfunction

  // Apply one accepted input transfer to the shadow store and queue its frames.
  function automatic void predict_frames(input in_item_t it);
    int               owed_before;
    int               lit_left;
    int               take;
    logic [FRAME_W-1:0] f;
    out_item_t        o;
    owed_before = pending_frames.size();
    case (it.kind) inside
      KIND_PIXEL: begin
        // Drop writes outside the store.
        if (it.pixel_col < TOTAL_COLS && it.pixel_row < MATRIX_ROWS)
          frame_pixels[it.pixel_row][it.pixel_col] = it.pixel_on;
      end
      KIND_CLEAR: push_clear();
      KIND_UPDATE: push_update();
      KIND_CMD_ONE, KIND_CMD_ALL: begin
        f = '0;
        for (int d = 0; d < CHAIN_DEVICES; d++) begin
          if (it.kind == KIND_CMD_ALL || d == int'(it.target_device))
            f = (f << WORD_BITS) | {it.register_addr, it.register_value};
          else
            f = (f << WORD_BITS) | {NOOP_BYTE, NOOP_BYTE};
        end
        push_frame(f);
      end
      KIND_FILL: begin
        push_clear();
        lit_left = (it.fill_count > FILL_MAX) ? FILL_MAX : int'(it.fill_count);
        for (int r = 0; r < BLOCK_SIZE && r < MATRIX_ROWS && lit_left > 0; r++) begin
          take = (lit_left >= BLOCK_SIZE) ? BLOCK_SIZE : lit_left;
          frame_pixels[r] = frame_pixels[r] | ROW_W'((32'd1 << take) - 1);
          lit_left -= take;
        end
        push_update();
      end
      default: ;  // unused kinds change nothing
    endcase
    // Flag the final frame of this transfer.
    if (pending_frames.size() > owed_before) begin
      o = pending_frames.pop_back();
      o.last_frame = 1'b1;
      pending_frames.push_back(o);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts and the result check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      // Hold off the block for a burst of random length.
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame transfer: chain_frame=%08h last_frame=%0b",
                 $time, out_data.chain_frame, out_data.last_frame);
        mismatch_count++;
      end else begin
        want = pending_frames.pop_front();
        if (out_data.chain_frame !== want.chain_frame) begin
          $display("%0t: chain_frame mismatch: expected %08h, actual %08h",
                   $time, want.chain_frame, out_data.chain_frame);
          mismatch_count++;
        end
        if (out_data.last_frame !== want.last_frame) begin
          $display("%0t: last_frame mismatch: expected %0b, actual %0b",
                   $time, want.last_frame, out_data.last_frame);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Fully random item of the given kind; callers overwrite the fields they care about.
  function automatic in_item_t make_item(input logic [2:0] kind);
    in_item_t it;
    it.kind           = kind;
    it.pixel_col      = 8'($urandom);
    it.pixel_row      = 8'($urandom);
    it.pixel_on       = 1'($urandom);
    it.target_device  = 1'($urandom);
    it.register_addr  = 8'($urandom);
    it.register_value = 8'($urandom);
    it.fill_count     = 8'($urandom);
    return it;
  endfunction

  // Present one item and wait for its transfer; valid stays high into the next item
  // unless a gap is inserted.
  task automatic send_item(input in_item_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_frames(it);
  endtask

  task automatic send_pixel(input int col, input int row, input logic on);
    in_item_t it;
    it           = make_item(KIND_PIXEL);
    it.pixel_col = 8'(col);
    it.pixel_row = 8'(row);
    it.pixel_on  = on;
    send_item(it);
  endtask

  task automatic send_command(input logic [2:0] kind, input logic tgt,
                              input logic [7:0] addr, input logic [7:0] val);
    in_item_t it;
    it                = make_item(kind);
    it.target_device  = tgt;
    it.register_addr  = addr;
    it.register_value = val;
    send_item(it);
  endtask

  task automatic send_fill(input logic [7:0] count);
    in_item_t it;
    it            = make_item(KIND_FILL);
    it.fill_count = count;
    send_item(it);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Store corners, writes just past each edge and far out, then darken a pixel and light two more.
  task automatic test_pixel_writes();
    send_pixel(0, 0, 1'b1);
    send_pixel(TOTAL_COLS - 1, MATRIX_ROWS - 1, 1'b1);
    send_pixel(TOTAL_COLS, 0, 1'b1);
    send_pixel(0, MATRIX_ROWS, 1'b1);
    send_pixel(255, 255, 1'b1);
    send_item(make_item(KIND_UPDATE));
    send_pixel(TOTAL_COLS - 1, MATRIX_ROWS - 1, 1'b0);
    send_pixel(7, 3, 1'b1);
    send_pixel(8, 3, 1'b1);
    send_item(make_item(KIND_UPDATE));
  endtask

  // One-device commands to each slot, a target past the chain if the chain is short,
  // and broadcasts at both extremes of address and data.
  task automatic test_register_commands();
    send_command(KIND_CMD_ONE, 1'b0, 8'hFF, 8'hFF);
    send_command(KIND_CMD_ONE, 1'b1, 8'h00, 8'hA5);
    send_command(KIND_CMD_ALL, 1'b0, 8'hFF, 8'hFF);
    send_command(KIND_CMD_ALL, 1'b1, 8'h00, 8'h00);
  endtask

  // Empty, single pixel, partial row, exact and saturated fill levels.
  task automatic test_fill_levels();
    send_fill(8'd0);
    send_fill(8'd1);
    send_fill(8'd9);
    send_fill(8'd64);
    send_fill(8'd255);
  endtask

  // Kinds past the last operation must leave the store alone; the update proves it.
  task automatic test_unused_kinds();
    send_item(make_item(3'd6));
    send_item(make_item(3'd7));
    send_item(make_item(KIND_UPDATE));
    send_item(make_item(KIND_CLEAR));
  endtask

  // Mostly pixel writes inside the store followed by updates, mixed with clears,
  // commands and fills; a share of fully random items as noise.
  task automatic test_random_traffic(input int item_goal);
    in_item_t it;
    int       sent;
    int       pick;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        it           = make_item(KIND_PIXEL);
        it.pixel_col = 8'($urandom_range(0, TOTAL_COLS - 1));
        it.pixel_row = 8'($urandom_range(0, MATRIX_ROWS - 1));
      end else if (pick < 65) begin
        it = make_item(KIND_UPDATE);
      end else if (pick < 70) begin
        it = make_item(KIND_CLEAR);
      end else if (pick < 78) begin
        it = make_item(KIND_CMD_ONE);
      end else if (pick < 84) begin
        it = make_item(KIND_CMD_ALL);
      end else if (pick < 91) begin
        it = make_item(KIND_FILL);
        if ($urandom_range(0, 3) != 0) it.fill_count = 8'($urandom_range(0, 72));
      end else begin
        it = make_item(3'($urandom_range(0, 7)));
      end
      send_item(it);
      // Count only transfers that do something.
      if (!(it.kind > KIND_FILL ||
            (it.kind == KIND_PIXEL &&
             (it.pixel_col >= TOTAL_COLS || it.pixel_row >= MATRIX_ROWS))))
        sent++;
    end
  endtask

  // Same traffic with both sides running flat out.
  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random_traffic(20);
  endtask

  initial begin
    for (int r = 0; r < MATRIX_ROWS; r++) frame_pixels[r] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_pixel_writes();
    test_register_commands();
    test_fill_levels();
    test_unused_kinds();
    test_random_traffic(70);
    test_back_to_back();

    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    // Let a stray late frame show up before the verdict.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("%0t: timeout, %0d frames still owed", $time, pending_frames.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== led_matrix_frame_buffer_driver.f =====
hw/rtl/lmfb_pkg.sv
hw/rtl/lmfb_ram.sv
hw/rtl/led_matrix_frame_buffer_driver.sv
sim/tb_led_matrix_frame_buffer_driver.sv
